// ===== design/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg: shared constants for the glyph bitmap to points block
// Glyph geometry, row width and the widths of the position counters.
// ----------------------------------------------------------------------------
package gbp_pkg;

   localparam int GLYPH_BYTES = 32;   // bytes in one glyph
   localparam int GLYPH_WIDTH = 16;   // bytes (columns) in one band of tiles
   localparam int ROW_BITS    = 8;    // pixels in one row byte

   localparam int COORD_W = 16;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = $clog2(GLYPH_BYTES);
   localparam int WIDTH_W = $clog2(GLYPH_WIDTH);
   localparam int TILE_W  = $clog2(ROW_BITS);

   localparam logic [COORD_W-1:0] TILE_STEP = COORD_W'(ROW_BITS);

endpackage

// ===== design/gbp_cursor.sv =====
// ----------------------------------------------------------------------------
// gbp_cursor: tile and band cursor of a glyph
// Gives the left column and row of the byte being accepted and steps the
// cursor to the next byte: down one row, right one tile, or down one band.
// ----------------------------------------------------------------------------
module gbp_cursor
   import gbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [COORD_W-1:0] origin_x,
   input  logic [COORD_W-1:0] origin_y,
   output logic [COORD_W-1:0] byte_col,
   output logic [COORD_W-1:0] byte_row
);

   logic [INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [WIDTH_W-1:0] width_cnt_ff, width_cnt_in;
   logic [TILE_W-1:0]  tile_cnt_ff, tile_cnt_in;
   logic [COORD_W-1:0] glyph_left_ff, glyph_left_in;
   logic [COORD_W-1:0] tile_col_ff, tile_col_in;
   logic [COORD_W-1:0] band_top_ff, band_top_in;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;

   logic               first;
   logic               glyph_end;
   logic               band_end;
   logic               tile_end;
   logic [COORD_W-1:0] left_eff;
   logic [COORD_W-1:0] band_eff;
   logic [COORD_W-1:0] band_next;

   always_comb begin
      first     = (byte_index_ff == '0);
      glyph_end = (byte_index_ff == INDEX_W'(GLYPH_BYTES - 1));
      band_end  = (width_cnt_ff == WIDTH_W'(GLYPH_WIDTH - 1));
      tile_end  = (tile_cnt_ff == TILE_W'(ROW_BITS - 1));

      // sample a new origin on the first byte of a glyph
      left_eff  = first ? origin_x : glyph_left_ff;
      band_eff  = first ? origin_y : band_top_ff;
      byte_col  = first ? origin_x : tile_col_ff;
      byte_row  = first ? origin_y : cur_row_ff;
      band_next = band_eff + TILE_STEP;

      byte_index_in = glyph_end ? '0 : byte_index_ff + 1'b1;
      width_cnt_in  = (glyph_end || band_end) ? '0 : width_cnt_ff + 1'b1;
      tile_cnt_in   = glyph_end ? '0 : tile_cnt_ff + 1'b1;
      glyph_left_in = left_eff;

      // the band step overrides the tile step when both land on this byte
      priority if (band_end) begin
         band_top_in = band_next;
         cur_row_in  = band_next;
         tile_col_in = left_eff;
      end else if (tile_end) begin
         band_top_in = band_eff;
         cur_row_in  = band_eff;
         tile_col_in = byte_col + TILE_STEP;
      end else begin
         band_top_in = band_eff;
         cur_row_in  = byte_row + 1'b1;
         tile_col_in = byte_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         width_cnt_ff  <= '0;
         tile_cnt_ff   <= '0;
         glyph_left_ff <= '0;
         tile_col_ff   <= '0;
         band_top_ff   <= '0;
         cur_row_ff    <= '0;
      end else if (advance) begin
         byte_index_ff <= byte_index_in;
         width_cnt_ff  <= width_cnt_in;
         tile_cnt_ff   <= tile_cnt_in;
         glyph_left_ff <= glyph_left_in;
         tile_col_ff   <= tile_col_in;
         band_top_ff   <= band_top_in;
         cur_row_ff    <= cur_row_in;
      end
   end

endmodule

// ===== design/glyph_bitmap_to_points.sv =====
// ----------------------------------------------------------------------------
// glyph_bitmap_to_points: glyph row bytes to lit pixel coordinates
// A row byte is accepted, then shifted out MSB first one pixel per cycle
// while no lit pixel stalls on a full output slot; each set pixel is sent
// as one point word, the last one of a byte marked. A new byte is taken
// only once no lit pixel is left in the row shifter, so a zero byte does
// not close the input.
// Reset: synchronous; clears the glyph cursor (next byte starts a glyph at
// origin sampling), the row shifter and the output valid flag.
// ----------------------------------------------------------------------------
module glyph_bitmap_to_points
   import gbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // font_byte[7:0], origin_x[23:8], origin_y[39:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // point_x[15:0], point_y[31:16]
   output logic        rsp_tlast    // last_point
);

   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_last_ff;

   logic               req_accept;
   logic               scanning;
   logic               stall;
   logic               emit;
   logic [COORD_W-1:0] byte_col;
   logic [COORD_W-1:0] byte_row;

   gbp_cursor u_cursor (
      .clock    (clock),
      .reset    (reset),
      .advance  (req_accept),
      .origin_x (req_tdata[23:8]),
      .origin_y (req_tdata[39:24]),
      .byte_col (byte_col),
      .byte_row (byte_row)
   );

   always_comb begin
      scanning   = (shift_ff != '0);
      // keep the input closed while in reset
      req_tready = !scanning && !reset;
      req_accept = req_tvalid && req_tready;
      // hold the shifter while a lit pixel waits for the output slot
      stall      = shift_ff[BYTE_W-1] && rsp_valid_ff && !rsp_tready;
      emit       = scanning && shift_ff[BYTE_W-1] && !stall;

      shift_in = shift_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      if (req_accept) begin
         shift_in = req_tdata[7:0];
         x_in     = byte_col;
         y_in     = byte_row;
      end else if (scanning && !stall) begin
         shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
         x_in     = x_ff + 1'b1;
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      if (emit) begin
         rsp_x_ff    <= x_ff;
         rsp_y_ff    <= y_ff;
         rsp_last_ff <= (shift_ff[BYTE_W-2:0] == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // a nonzero row byte keeps the input closed on the next cycle
   a_busy_after_byte: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tdata[7:0] != '0)) |=> !req_tready)
      else $error("input open while a row byte is still being scanned");

   // the marked point is the final lit pixel: shifter empties with it
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (emit && (shift_ff[BYTE_W-2:0] == '0)) |=> (shift_ff == '0))
      else $error("pixels left in the shifter after the last point");

   // column steps by one for every pixel shifted out
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      (scanning && !stall) |=> (x_ff == $past(x_ff) + 1'b1))
      else $error("column did not follow the pixel shift");

   // a stalled point never loses its pixel
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> (shift_ff == $past(shift_ff)) && rsp_tvalid)
      else $error("shifter moved while the output slot was full");
`endif

endmodule
